[rtl/mcfs_pkg.sv]
// ============================================================================
// mcfs_pkg: shared types and constants of the four-camera frame synchronizer
// Queue geometry, payload layouts, arithmetic unit codes and sequencer states.
// ============================================================================
package mcfs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_CAMS    = 4;
    localparam int CAM_W       = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int ADDR_W      = CAM_W + PTR_W;
    localparam int MEM_DEPTH   = NUM_CAMS << PTR_W;

    localparam int STAMP_W = 48;
    localparam int FRAME_W = 32;
    localparam int GROUP_W = 32;
    localparam int THR_W   = 20;
    localparam int DISC_W  = 6;
    // two guard bits so the sum of four stamps fits
    localparam int ALU_W   = STAMP_W + 2;

    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(10000);
    localparam logic [DISC_W-1:0] DISC_MAX   = '1;
    localparam logic [CNT_W-1:0]  FILL_FULL  = CNT_W'(QUEUE_DEPTH);

    // one queue entry
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [FRAME_W-1:0] frame;
    } q_entry_t;

    // queue memory write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        q_entry_t          data;
    } mem_wr_t;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [1:0]         pad;
        logic [DISC_W-1:0]  discarded;
        logic [FRAME_W-1:0] frame_cam3;
        logic [FRAME_W-1:0] frame_cam2;
        logic [FRAME_W-1:0] frame_cam1;
        logic [FRAME_W-1:0] frame_cam0;
        logic [STAMP_W-1:0] stamp_cam3;
        logic [STAMP_W-1:0] stamp_cam2;
        logic [STAMP_W-1:0] stamp_cam1;
        logic [STAMP_W-1:0] stamp_cam0;
        logic [STAMP_W-1:0] avg_stamp;
        logic [GROUP_W-1:0] group_number;
    } out_item_t;

    localparam int OUT_W = $bits(out_item_t);

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'h0001,
        ST_PUSH   = 13'h0002,
        ST_CHECK  = 13'h0004,
        ST_RD     = 13'h0008,
        ST_LD     = 13'h0010,
        ST_MIN    = 13'h0020,
        ST_MAX    = 13'h0040,
        ST_SPREAD = 13'h0080,
        ST_THRESH = 13'h0100,
        ST_SUM    = 13'h0200,
        ST_GROUP  = 13'h0400,
        ST_DROP   = 13'h0800,
        ST_DONE   = 13'h1000
    } state_t;

    // circular pointer advance
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

endpackage

[rtl/mcfs_queue_mem.sv]
// ============================================================================
// mcfs_queue_mem: frame queue storage
// Four camera queues in one memory, one write and one registered read port.
// ============================================================================
module mcfs_queue_mem
    import mcfs_pkg::*;
(
    input  logic              clk,
    input  mem_wr_t           wr,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output q_entry_t          rd_data
);

    q_entry_t mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/mcfs_alu.sv]
// ============================================================================
// mcfs_alu: shared add / subtract unit
// Serves the min and max compares, the spread check and the stamp sum.
// ============================================================================
module mcfs_alu
    import mcfs_pkg::*;
(
    input  alu_op_t          op,
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output logic [ALU_W:0]   y      // top bit is the borrow on subtract
);

    always_comb
    begin
        unique case (op)
            ALU_ADD: y = {1'b0, a} + {1'b0, b};
            ALU_SUB: y = {1'b0, a} - {1'b0, b};
            default: y = '0;
        endcase
    end

endmodule

[rtl/multi_camera_frame_synchronizer.sv]
// ============================================================================
// multi_camera_frame_synchronizer: four-stream approximate time sync
// Queues camera frames per camera and groups heads whose stamps lie close.
// ============================================================================
// Each input item is one frame arrival (camera on tuser, microsecond stamp on
// tdata). The frame takes the camera's running frame number and goes into that
// camera's queue of QUEUE_DEPTH entries; a full queue drops its oldest entry.
// While all four queues hold a frame, the sequencer reads the four heads from
// the queue memory one at a time, finds earliest and latest with one shared
// add/subtract unit, and either pops all four as a group (spread within
// sync_threshold) or drops the earliest head, lowest camera first on ties.
// Every input item yields exactly one result item; tuser marks a formed group.
// Timing: the block takes one item at a time and is not ready until the item
// is finished. Each pass reads every head in turn (memory read, load, min
// compare and max compare through the shared unit), computes the spread and
// checks it against the threshold, then pops the earliest head or sums the
// stamps and pops the group, and rechecks the queues. A finished result waits
// in the output register, so the next item is taken while it is still pending;
// the item after that waits at its end until the output register is free.
// sync_threshold is written through the cfg channel, which is always ready;
// write it only while the block is idle. Reset value is 10000 us.
// ============================================================================
module multi_camera_frame_synchronizer
    import mcfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [STAMP_W-1:0] s_axis_tdata,   // arrival_stamp
    input  logic [CAM_W-1:0]   s_axis_tuser,   // camera

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // group_number, avg_stamp, stamp_cam0..3, frame_cam0..3, discarded, pad
    output logic [OUT_W-1:0]   m_axis_tdata,
    output logic [0:0]         m_axis_tuser,   // group_valid

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [THR_W-1:0]   cfg_data        // sync_threshold
);

    // ---------------------------------------------------------------- control
    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   rp_reg   [NUM_CAMS];
    logic [PTR_W-1:0]   rp_next  [NUM_CAMS];
    logic [CNT_W-1:0]   fill_reg [NUM_CAMS];
    logic [CNT_W-1:0]   fill_next[NUM_CAMS];
    logic [FRAME_W-1:0] fcnt_reg [NUM_CAMS];
    logic [FRAME_W-1:0] fcnt_next[NUM_CAMS];
    logic [GROUP_W-1:0] gcnt_reg, gcnt_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic [CAM_W-1:0]   k_reg, k_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_group_reg, out_group_next;   // group flag of the output item

    // ---------------------------------------------------------------- working
    logic [CAM_W-1:0]   cam_reg, cam_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [STAMP_W-1:0] lo_reg, lo_next;
    logic [STAMP_W-1:0] hi_reg, hi_next;
    logic [CAM_W-1:0]   lo_cam_reg, lo_cam_next;
    logic [STAMP_W-1:0] diff_reg, diff_next;
    logic [ALU_W-1:0]   sum_reg, sum_next;
    logic [DISC_W-1:0]  drops_reg, drops_next;
    logic [STAMP_W-1:0] head_stamp_reg [NUM_CAMS];
    logic [STAMP_W-1:0] head_stamp_next[NUM_CAMS];
    logic [FRAME_W-1:0] head_frame_reg [NUM_CAMS];
    logic [FRAME_W-1:0] head_frame_next[NUM_CAMS];
    logic               res_valid_reg, res_valid_next;
    out_item_t          res_reg, res_next;        // group fields of this item
    out_item_t          out_reg, out_next;

    // ---------------------------------------------------------------- datapath
    logic [CAM_W-1:0]   acc_cam;
    logic [PTR_W-1:0]   acc_rp;
    logic [CNT_W-1:0]   acc_fill;
    logic [FRAME_W-1:0] acc_fcnt;
    logic [SUM_W-1:0]   wr_sum;
    logic [PTR_W-1:0]   wr_idx;
    logic               all_present;

    mem_wr_t            mem_wr;
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_rd_addr;
    q_entry_t           mem_rd_data;

    alu_op_t            alu_op;
    logic [ALU_W-1:0]   alu_a, alu_b;
    logic [ALU_W:0]     alu_y;
    logic               alu_borrow;

    mcfs_queue_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    mcfs_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign alu_borrow = alu_y[ALU_W];

    // single camera port into the small per-camera tables
    always_comb
    begin
        unique case (state_reg)
            ST_PUSH: acc_cam = cam_reg;
            ST_DROP: acc_cam = lo_cam_reg;
            default: acc_cam = k_reg;
        endcase
    end

    assign acc_rp   = rp_reg[acc_cam];
    assign acc_fill = fill_reg[acc_cam];
    assign acc_fcnt = fcnt_reg[acc_cam];

    // tail slot: read pointer plus fill, wrapped once
    assign wr_sum = SUM_W'(acc_rp) + SUM_W'(acc_fill);
    assign wr_idx = (wr_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    PTR_W'(wr_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(wr_sum);

    always_comb
    begin
        all_present = 1'b1;
        for (int c = 0; c < NUM_CAMS; c++)
        begin
            if (fill_reg[c] == '0)
                all_present = 1'b0;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next      = state_reg;
        rp_next         = rp_reg;
        fill_next       = fill_reg;
        fcnt_next       = fcnt_reg;
        gcnt_next       = gcnt_reg;
        thr_next        = thr_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_group_next  = out_group_reg;
        cam_next        = cam_reg;
        stamp_next      = stamp_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        lo_cam_next     = lo_cam_reg;
        diff_next       = diff_reg;
        sum_next        = sum_reg;
        drops_next      = drops_reg;
        head_stamp_next = head_stamp_reg;
        head_frame_next = head_frame_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        out_next        = out_reg;

        mem_wr          = '0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = {acc_cam, acc_rp};
        alu_op          = ALU_SUB;
        alu_a           = '0;
        alu_b           = '0;

        if (cfg_valid)
            thr_next = cfg_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cam_next       = s_axis_tuser;
                    stamp_next     = s_axis_tdata;
                    drops_next     = '0;
                    res_valid_next = 1'b0;
                    state_next     = ST_PUSH;
                end
            end

            ST_PUSH:
            begin
                mem_wr.en         = 1'b1;
                mem_wr.data.stamp = stamp_reg;
                mem_wr.data.frame = acc_fcnt;
                fcnt_next[acc_cam] = acc_fcnt + FRAME_W'(1);
                if (acc_fill == FILL_FULL)
                begin
                    // overwrite the oldest slot and move the head past it
                    mem_wr.addr      = {acc_cam, acc_rp};
                    rp_next[acc_cam] = ptr_inc(acc_rp);
                    drops_next       = DISC_W'(1);
                end
                else
                begin
                    mem_wr.addr        = {acc_cam, wr_idx};
                    fill_next[acc_cam] = acc_fill + CNT_W'(1);
                end
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                k_next     = '0;
                state_next = all_present ? ST_RD : ST_DONE;
            end

            ST_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_LD;
            end

            ST_LD:
            begin
                head_stamp_next[k_reg] = mem_rd_data.stamp;
                head_frame_next[k_reg] = mem_rd_data.frame;
                if (k_reg == '0)
                begin
                    lo_next     = mem_rd_data.stamp;
                    hi_next     = mem_rd_data.stamp;
                    lo_cam_next = '0;
                end
                state_next = ST_MIN;
            end

            ST_MIN:
            begin
                // strictly earlier only, so ties stay with the lower camera
                alu_a = ALU_W'(mem_rd_data.stamp);
                alu_b = ALU_W'(lo_reg);
                if (alu_borrow)
                begin
                    lo_next     = mem_rd_data.stamp;
                    lo_cam_next = k_reg;
                end
                state_next = ST_MAX;
            end

            ST_MAX:
            begin
                alu_a = ALU_W'(hi_reg);
                alu_b = ALU_W'(mem_rd_data.stamp);
                if (alu_borrow)
                    hi_next = mem_rd_data.stamp;
                if (k_reg == CAM_W'(NUM_CAMS - 1))
                begin
                    state_next = ST_SPREAD;
                end
                else
                begin
                    k_next     = k_reg + CAM_W'(1);
                    state_next = ST_RD;
                end
            end

            ST_SPREAD:
            begin
                alu_a      = ALU_W'(hi_reg);
                alu_b      = ALU_W'(lo_reg);
                diff_next  = alu_y[STAMP_W-1:0];
                state_next = ST_THRESH;
            end

            ST_THRESH:
            begin
                // borrow means threshold below spread
                alu_a  = ALU_W'(thr_reg);
                alu_b  = ALU_W'(diff_reg);
                k_next = '0;
                sum_next = '0;
                state_next = alu_borrow ? ST_DROP : ST_SUM;
            end

            ST_SUM:
            begin
                alu_op   = ALU_ADD;
                alu_a    = sum_reg;
                alu_b    = ALU_W'(head_stamp_reg[k_reg]);
                sum_next = alu_y[ALU_W-1:0];
                if (k_reg == CAM_W'(NUM_CAMS - 1))
                    state_next = ST_GROUP;
                else
                    k_next = k_reg + CAM_W'(1);
            end

            ST_GROUP:
            begin
                res_valid_next       = 1'b1;
                res_next.group_number = gcnt_reg;
                res_next.avg_stamp    = sum_reg[STAMP_W+1:2];
                res_next.stamp_cam0   = head_stamp_reg[0];
                res_next.stamp_cam1   = head_stamp_reg[1];
                res_next.stamp_cam2   = head_stamp_reg[2];
                res_next.stamp_cam3   = head_stamp_reg[3];
                res_next.frame_cam0   = head_frame_reg[0];
                res_next.frame_cam1   = head_frame_reg[1];
                res_next.frame_cam2   = head_frame_reg[2];
                res_next.frame_cam3   = head_frame_reg[3];
                gcnt_next = gcnt_reg + GROUP_W'(1);
                for (int c = 0; c < NUM_CAMS; c++)
                begin
                    rp_next[c]   = ptr_inc(rp_reg[c]);
                    fill_next[c] = fill_reg[c] - CNT_W'(1);
                end
                state_next = ST_CHECK;
            end

            ST_DROP:
            begin
                rp_next[acc_cam]   = ptr_inc(acc_rp);
                fill_next[acc_cam] = acc_fill - CNT_W'(1);
                if (drops_reg != DISC_MAX)
                    drops_next = drops_reg + DISC_W'(1);
                state_next = ST_CHECK;
            end

            ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || m_axis_tready)
                begin
                    if (res_valid_reg)
                        out_next = res_reg;
                    else
                        out_next = '0;
                    out_next.pad       = '0;
                    out_next.discarded = drops_reg;
                    out_valid_next     = 1'b1;
                    out_group_next     = res_valid_reg;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gcnt_reg      <= '0;
            thr_reg       <= THR_RESET;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_group_reg <= 1'b0;
            for (int c = 0; c < NUM_CAMS; c++)
            begin
                rp_reg[c]   <= '0;
                fill_reg[c] <= '0;
                fcnt_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            gcnt_reg      <= gcnt_next;
            thr_reg       <= thr_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            out_group_reg <= out_group_next;
            rp_reg        <= rp_next;
            fill_reg      <= fill_next;
            fcnt_reg      <= fcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cam_reg        <= cam_next;
        stamp_reg      <= stamp_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        lo_cam_reg     <= lo_cam_next;
        diff_reg       <= diff_next;
        sum_reg        <= sum_next;
        drops_reg      <= drops_next;
        head_stamp_reg <= head_stamp_next;
        head_frame_reg <= head_frame_next;
        res_valid_reg  <= res_valid_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

    // ---------------------------------------------------------------- ports
    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_reg;
    assign m_axis_tuser[0] = out_group_reg;
    assign cfg_ready       = 1'b1;

    // ---------------------------------------------------------------- checks
    a_group_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GROUP |=> gcnt_reg == $past(gcnt_reg) + GROUP_W'(1))
        else $error("group counter did not advance by one");

    a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DROP |-> fill_reg[lo_cam_reg] != '0)
        else $error("dropping head of an empty queue");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[0] <= FILL_FULL && fill_reg[1] <= FILL_FULL &&
        fill_reg[2] <= FILL_FULL && fill_reg[3] <= FILL_FULL)
        else $error("queue fill above depth");

    a_spread_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_THRESH |-> hi_reg >= lo_reg)
        else $error("latest head stamp below earliest");

endmodule
